[design/look_at_view_matrix_core_assert.svh]
// Assertion macros for the look-at view matrix core.
// Depends on a clock named clock and a synchronous reset named reset in the using module.
`ifndef LOOK_AT_VIEW_MATRIX_CORE_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LAV_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LAV_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[design/lav_pkg.sv]
// Shared widths, vector types and row codes for the look-at view matrix core.
// No dependencies.
package lav_pkg;

   localparam int FRAC_BITS = 16;
   localparam int BW        = FRAC_BITS + 2;  // signed unit component width
   localparam int VW        = 64;             // width of a vector to normalize
   localparam int COL_W     = 18;             // output column width
   localparam int PW        = 32 + BW;        // 32-bit by component product

   typedef logic [2:0][31:0]    word3_type;
   typedef logic [2:0][BW-1:0]  basis3_type;
   typedef logic [2:0][VW-1:0]  wide3_type;

   typedef logic [1:0] row_type;
   localparam row_type ROW_X = 2'd0;
   localparam row_type ROW_Y = 2'd1;
   localparam row_type ROW_Z = 2'd2;

   // data that rides along the pipeline with each camera word
   typedef struct packed {
      word3_type  target;
      word3_type  up;
      basis3_type zb;
      basis3_type xb;
      logic       ok;
   } lav_side_type;

endpackage

[design/look_at_view_matrix_core.sv]
// Look-at view matrix core: takes eye, target and up in signed Q16.16 and returns
// the three upper rows of the view matrix (basis vector plus translation -(row . target),
// rounded and saturated to Q16.16). A word is taken when start is high and busy is low;
// busy then holds off further words, so camera words are taken no faster than the three
// result rows need on the result port. Rows come out on consecutive cycles, x, y, z, each
// marked by rsp_strobe for one cycle; the receiver cannot stall, so rows must be taken
// as they appear. The delay from the taking edge to the first row is set mostly by the
// 31-stage square root and the (FRAC_BITS+1)-stage dividers in each of the three
// normalizers.
// A zero-length vector gives identity rows with rsp_degenerate set.
// Depends on lav_pkg, lav_norm, lav_cross, lav_emit and the assertion header.
`include "look_at_view_matrix_core_assert.svh"

module look_at_view_matrix_core import lav_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [31:0]      req_eye_x,
   input  logic signed [31:0]      req_eye_y,
   input  logic signed [31:0]      req_eye_z,
   input  logic signed [31:0]      req_target_x,
   input  logic signed [31:0]      req_target_y,
   input  logic signed [31:0]      req_target_z,
   input  logic signed [31:0]      req_up_x,
   input  logic signed [31:0]      req_up_y,
   input  logic signed [31:0]      req_up_z,
   output logic                    rsp_strobe,
   output row_type                 rsp_row_index,
   output logic signed [COL_W-1:0] rsp_col0,
   output logic signed [COL_W-1:0] rsp_col1,
   output logic signed [COL_W-1:0] rsp_col2,
   output logic signed [31:0]      rsp_shift,
   output logic                    rsp_last_row,
   output logic                    rsp_degenerate
);

   // input pacing: a new word is taken only while busy is low
   logic [1:0] busy_cnt_ff;
   logic       accept;

   assign accept = start & ~busy;
   assign busy   = (busy_cnt_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (reset)                   busy_cnt_ff <= 2'd0;
      else if (accept)             busy_cnt_ff <= 2'd2;
      else if (busy_cnt_ff != 2'd0) busy_cnt_ff <= busy_cnt_ff - 2'd1;
   end

   // entry stage: view direction eye - target
   logic         in_valid_ff;
   wide3_type    in_d_ff;
   lav_side_type in_side_ff;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= accept;
      in_d_ff[0] <= VW'(33'(req_eye_x) - 33'(req_target_x));
      in_d_ff[1] <= VW'(33'(req_eye_y) - 33'(req_target_y));
      in_d_ff[2] <= VW'(33'(req_eye_z) - 33'(req_target_z));
      in_side_ff.target <= {req_target_z, req_target_y, req_target_x};
      in_side_ff.up     <= {req_up_z, req_up_y, req_up_x};
      in_side_ff.zb     <= '0;
      in_side_ff.xb     <= '0;
      in_side_ff.ok     <= 1'b1;
   end

   // z axis
   logic         z_valid;
   basis3_type   z_vec;
   lav_side_type z_side_raw, z_side;

   lav_norm u_norm_z (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_vec   (in_d_ff),
      .in_side  (in_side_ff),
      .out_valid(z_valid),
      .out_vec  (z_vec),
      .out_side (z_side_raw)
   );

   always_comb begin
      z_side    = z_side_raw;
      z_side.zb = z_vec;
   end

   // x axis: up cross z
   logic         cx_valid;
   wide3_type    cx_vec;
   lav_side_type cx_side;

   lav_cross u_cross_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (z_valid),
      .in_a     (z_side.up),
      .in_b     (z_vec),
      .in_side  (z_side),
      .out_valid(cx_valid),
      .out_vec  (cx_vec),
      .out_side (cx_side)
   );

   logic         x_valid;
   basis3_type   x_vec;
   lav_side_type x_side_raw, x_side;

   lav_norm u_norm_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (cx_valid),
      .in_vec   (cx_vec),
      .in_side  (cx_side),
      .out_valid(x_valid),
      .out_vec  (x_vec),
      .out_side (x_side_raw)
   );

   // y axis: z cross x
   word3_type z_wide;

   always_comb begin
      x_side    = x_side_raw;
      x_side.xb = x_vec;
      for (int i = 0; i < 3; i++) z_wide[i] = 32'($signed(x_side_raw.zb[i]));
   end

   logic         cy_valid;
   wide3_type    cy_vec;
   lav_side_type cy_side;

   lav_cross u_cross_y (
      .clock    (clock),
      .reset    (reset),
      .in_valid (x_valid),
      .in_a     (z_wide),
      .in_b     (x_vec),
      .in_side  (x_side),
      .out_valid(cy_valid),
      .out_vec  (cy_vec),
      .out_side (cy_side)
   );

   logic         y_valid;
   basis3_type   y_vec;
   lav_side_type y_side;

   lav_norm u_norm_y (
      .clock    (clock),
      .reset    (reset),
      .in_valid (cy_valid),
      .in_vec   (cy_vec),
      .in_side  (cy_side),
      .out_valid(y_valid),
      .out_vec  (y_vec),
      .out_side (y_side)
   );

   // translation and row output
   lav_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (y_valid),
      .in_yb         (y_vec),
      .in_side       (y_side),
      .rsp_strobe    (rsp_strobe),
      .rsp_row_index (rsp_row_index),
      .rsp_col0      (rsp_col0),
      .rsp_col1      (rsp_col1),
      .rsp_col2      (rsp_col2),
      .rsp_shift     (rsp_shift),
      .rsp_last_row  (rsp_last_row),
      .rsp_degenerate(rsp_degenerate)
   );

   // checks
   `LAV_ASSERT_NEXT(a_busy_after_accept, accept, busy, "busy not raised after a taken word")
   `LAV_ASSERT_NEXT(a_row_sequence, rsp_strobe && (rsp_row_index != ROW_Z),
      rsp_strobe && (rsp_row_index == $past(rsp_row_index) + 2'd1),
      "result rows not consecutive")
   `LAV_ASSERT_NEXT(a_flag_steady, rsp_strobe && (rsp_row_index != ROW_Z),
      $stable(rsp_degenerate), "degenerate flag changed within a matrix")
   `LAV_ASSERT_NOW(a_first_row, rsp_strobe && !$past(rsp_strobe),
      rsp_row_index == ROW_X, "matrix did not start on the x row")

endmodule

[design/lav_norm.sv]
// Pipelined vector normalizer: scale, squared length, root and three dividers.
// Depends on lav_pkg.
module lav_norm import lav_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  wide3_type    in_vec,
   input  lav_side_type in_side,
   output logic         out_valid,
   output basis3_type   out_vec,
   output lav_side_type out_side
);

   localparam int SW       = 30;               // scaled magnitude width
   localparam int SQ_STEPS = 31;               // root bits
   localparam int XW       = 2 * SQ_STEPS;     // squared length width
   localparam int RW       = 34;               // root remainder width
   localparam int QB       = FRAC_BITS + 1;    // quotient bits
   localparam int NW       = SW + 1 + FRAC_BITS; // numerator width
   localparam int DRW      = SQ_STEPS;         // divider remainder width

   // stage A: magnitudes and signs
   logic                 a_valid_ff;
   logic [2:0][VW-1:0]   a_mag_ff, a_mag_in;
   logic [2:0]           a_neg_ff;
   lav_side_type         a_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_mag_in[i] = in_vec[i][VW-1] ? (VW'(0) - in_vec[i]) : in_vec[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else       a_valid_ff <= in_valid;
      a_mag_ff  <= a_mag_in;
      a_neg_ff  <= {in_vec[2][VW-1], in_vec[1][VW-1], in_vec[0][VW-1]};
      a_side_ff <= in_side;
   end

   // stage B: largest magnitude, zero-length check
   logic                 b_valid_ff;
   logic [2:0][VW-1:0]   b_mag_ff;
   logic [VW-1:0]        b_mx_ff, b_mx_in, b_mx01;
   logic [2:0]           b_neg_ff;
   lav_side_type         b_side_ff, b_side_in;

   always_comb begin
      b_mx01  = (a_mag_ff[0] > a_mag_ff[1]) ? a_mag_ff[0] : a_mag_ff[1];
      b_mx_in = (b_mx01 > a_mag_ff[2]) ? b_mx01 : a_mag_ff[2];
      b_side_in    = a_side_ff;
      b_side_in.ok = a_side_ff.ok & (b_mx_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else       b_valid_ff <= a_valid_ff;
      b_mag_ff  <= a_mag_ff;
      b_mx_ff   <= b_mx_in;
      b_neg_ff  <= a_neg_ff;
      b_side_ff <= b_side_in;
   end

   // stages C: left-justify, two shift steps per stage
   logic                 c_valid_ff [3];
   logic [2:0][VW-1:0]   c_mag_ff   [3];
   logic [VW-1:0]        c_mx_ff    [3];
   logic [2:0]           c_neg_ff   [3];
   lav_side_type         c_side_ff  [3];

   for (genvar k = 0; k < 3; k++) begin : g_nrm
      localparam int SH_A = 32 >> (2 * k);
      localparam int SH_B = SH_A / 2;
      logic               src_valid;
      logic [2:0][VW-1:0] src_mag, mid_mag, nxt_mag;
      logic [VW-1:0]      src_mx, mid_mx, nxt_mx;
      logic [2:0]         src_neg;
      lav_side_type       src_side;

      if (k == 0) begin : g_head
         assign src_valid = b_valid_ff;
         assign src_mag   = b_mag_ff;
         assign src_mx    = b_mx_ff;
         assign src_neg   = b_neg_ff;
         assign src_side  = b_side_ff;
      end else begin : g_body
         assign src_valid = c_valid_ff[k-1];
         assign src_mag   = c_mag_ff[k-1];
         assign src_mx    = c_mx_ff[k-1];
         assign src_neg   = c_neg_ff[k-1];
         assign src_side  = c_side_ff[k-1];
      end

      always_comb begin
         mid_mx  = src_mx;
         mid_mag = src_mag;
         if (src_mx[VW-1 -: SH_A] == '0) begin
            mid_mx = src_mx << SH_A;
            for (int i = 0; i < 3; i++) mid_mag[i] = src_mag[i] << SH_A;
         end
         nxt_mx  = mid_mx;
         nxt_mag = mid_mag;
         if (mid_mx[VW-1 -: SH_B] == '0) begin
            nxt_mx = mid_mx << SH_B;
            for (int i = 0; i < 3; i++) nxt_mag[i] = mid_mag[i] << SH_B;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) c_valid_ff[k] <= 1'b0;
         else       c_valid_ff[k] <= src_valid;
         c_mag_ff[k]  <= nxt_mag;
         c_mx_ff[k]   <= nxt_mx;
         c_neg_ff[k]  <= src_neg;
         c_side_ff[k] <= src_side;
      end
   end

   // stage E: leading one now at the top; keep SW bits and square them
   logic                   e_valid_ff;
   logic [2:0][SW-1:0]     e_s_ff, e_s_in;
   logic [2:0][2*SW-1:0]   e_sq_ff, e_sq_in;
   logic [2:0]             e_neg_ff;
   lav_side_type           e_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e_s_in[i]  = c_mag_ff[2][i][VW-1 -: SW];
         e_sq_in[i] = e_s_in[i] * e_s_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else       e_valid_ff <= c_valid_ff[2];
      e_s_ff    <= e_s_in;
      e_sq_ff   <= e_sq_in;
      e_neg_ff  <= c_neg_ff[2];
      e_side_ff <= c_side_ff[2];
   end

   // stage F: squared length
   logic               f_valid_ff;
   logic [XW-1:0]      f_len2_ff;
   logic [2:0][SW-1:0] f_s_ff;
   logic [2:0]         f_neg_ff;
   lav_side_type       f_side_ff;

   always_ff @(posedge clock) begin
      if (reset) f_valid_ff <= 1'b0;
      else       f_valid_ff <= e_valid_ff;
      f_len2_ff <= XW'(e_sq_ff[0]) + XW'(e_sq_ff[1]) + XW'(e_sq_ff[2]);
      f_s_ff    <= e_s_ff;
      f_neg_ff  <= e_neg_ff;
      f_side_ff <= e_side_ff;
   end

   // stages G: integer square root, one bit a stage
   logic                 g_valid_ff [SQ_STEPS];
   logic [RW-1:0]        g_rem_ff   [SQ_STEPS];
   logic [SQ_STEPS-1:0]  g_root_ff  [SQ_STEPS];
   logic [XW-1:0]        g_x_ff     [SQ_STEPS];
   logic [2:0][SW-1:0]   g_s_ff     [SQ_STEPS];
   logic [2:0]           g_neg_ff   [SQ_STEPS];
   lav_side_type         g_side_ff  [SQ_STEPS];

   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
      localparam int XH = XW - 1 - 2 * j;
      logic                src_valid;
      logic [RW-1:0]       src_rem, trial, part, nxt_rem;
      logic [SQ_STEPS-1:0] src_root, nxt_root;
      logic [XW-1:0]       src_x;
      logic [2:0][SW-1:0]  src_s;
      logic [2:0]          src_neg;
      lav_side_type        src_side;
      logic                ge;

      if (j == 0) begin : g_head
         assign src_valid = f_valid_ff;
         assign src_rem   = '0;
         assign src_root  = '0;
         assign src_x     = f_len2_ff;
         assign src_s     = f_s_ff;
         assign src_neg   = f_neg_ff;
         assign src_side  = f_side_ff;
      end else begin : g_body
         assign src_valid = g_valid_ff[j-1];
         assign src_rem   = g_rem_ff[j-1];
         assign src_root  = g_root_ff[j-1];
         assign src_x     = g_x_ff[j-1];
         assign src_s     = g_s_ff[j-1];
         assign src_neg   = g_neg_ff[j-1];
         assign src_side  = g_side_ff[j-1];
      end

      always_comb begin
         part     = {src_rem[RW-3:0], src_x[XH -: 2]};
         trial    = {1'b0, src_root, 2'b01};
         ge       = (part >= trial);
         nxt_rem  = ge ? (part - trial) : part;
         nxt_root = {src_root[SQ_STEPS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) g_valid_ff[j] <= 1'b0;
         else       g_valid_ff[j] <= src_valid;
         g_rem_ff[j]  <= nxt_rem;
         g_root_ff[j] <= nxt_root;
         g_x_ff[j]    <= src_x;
         g_s_ff[j]    <= src_s;
         g_neg_ff[j]  <= src_neg;
         g_side_ff[j] <= src_side;
      end
   end

   // stage H: rounded numerators s * 2^F + L/2
   logic                 h_valid_ff;
   logic [2:0][NW-1:0]   h_num_ff, h_num_in;
   logic [SQ_STEPS-1:0]  h_len_ff;
   logic [2:0]           h_neg_ff;
   lav_side_type         h_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         h_num_in[i] = NW'({g_s_ff[SQ_STEPS-1][i], {FRAC_BITS{1'b0}}})
                     + NW'(g_root_ff[SQ_STEPS-1] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) h_valid_ff <= 1'b0;
      else       h_valid_ff <= g_valid_ff[SQ_STEPS-1];
      h_num_ff  <= h_num_in;
      h_len_ff  <= g_root_ff[SQ_STEPS-1];
      h_neg_ff  <= g_neg_ff[SQ_STEPS-1];
      h_side_ff <= g_side_ff[SQ_STEPS-1];
   end

   // stages D: restoring dividers, three lanes, one quotient bit a stage
   logic                 d_valid_ff [QB];
   logic [2:0][DRW-1:0]  d_rem_ff   [QB];
   logic [2:0][QB-1:0]   d_quo_ff   [QB];
   logic [2:0][NW-1:0]   d_num_ff   [QB];
   logic [SQ_STEPS-1:0]  d_len_ff   [QB];
   logic [2:0]           d_neg_ff   [QB];
   lav_side_type         d_side_ff  [QB];

   for (genvar j = 0; j < QB; j++) begin : g_div
      logic                src_valid;
      logic [2:0][DRW-1:0] src_rem, nxt_rem;
      logic [2:0][QB-1:0]  src_quo, nxt_quo;
      logic [2:0][NW-1:0]  src_num;
      logic [SQ_STEPS-1:0] src_len;
      logic [2:0]          src_neg;
      lav_side_type        src_side;
      logic [DRW:0]        part [3];
      logic [2:0]          ge;

      if (j == 0) begin : g_head
         assign src_valid = h_valid_ff;
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign src_rem[i] = DRW'(h_num_ff[i][NW-1:QB]);
         end
         assign src_quo   = '0;
         assign src_num   = h_num_ff;
         assign src_len   = h_len_ff;
         assign src_neg   = h_neg_ff;
         assign src_side  = h_side_ff;
      end else begin : g_body
         assign src_valid = d_valid_ff[j-1];
         assign src_rem   = d_rem_ff[j-1];
         assign src_quo   = d_quo_ff[j-1];
         assign src_num   = d_num_ff[j-1];
         assign src_len   = d_len_ff[j-1];
         assign src_neg   = d_neg_ff[j-1];
         assign src_side  = d_side_ff[j-1];
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            part[i]    = {src_rem[i], src_num[i][QB-1-j]};
            ge[i]      = (part[i] >= {1'b0, src_len});
            nxt_rem[i] = ge[i] ? DRW'(part[i] - {1'b0, src_len}) : part[i][DRW-1:0];
            nxt_quo[i] = {src_quo[i][QB-2:0], ge[i]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) d_valid_ff[j] <= 1'b0;
         else       d_valid_ff[j] <= src_valid;
         d_rem_ff[j]  <= nxt_rem;
         d_quo_ff[j]  <= nxt_quo;
         d_num_ff[j]  <= src_num;
         d_len_ff[j]  <= src_len;
         d_neg_ff[j]  <= src_neg;
         d_side_ff[j] <= src_side;
      end
   end

   // output stage: restore signs
   logic         o_valid_ff;
   basis3_type   o_vec_ff, o_vec_in;
   lav_side_type o_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         o_vec_in[i] = d_neg_ff[QB-1][i] ? (BW'(0) - BW'(d_quo_ff[QB-1][i]))
                                         : BW'(d_quo_ff[QB-1][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) o_valid_ff <= 1'b0;
      else       o_valid_ff <= d_valid_ff[QB-1];
      o_vec_ff  <= o_vec_in;
      o_side_ff <= d_side_ff[QB-1];
   end

   assign out_valid = o_valid_ff;
   assign out_vec   = o_vec_ff;
   assign out_side  = o_side_ff;

endmodule

[design/lav_cross.sv]
// Two-stage cross product of a 32-bit vector and a unit basis vector.
// Depends on lav_pkg.
module lav_cross import lav_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  word3_type    in_a,
   input  basis3_type   in_b,
   input  lav_side_type in_side,
   output logic         out_valid,
   output wide3_type    out_vec,
   output lav_side_type out_side
);

   // stage 1: six products
   logic               p_valid_ff;
   logic [5:0][PW-1:0] p_ff, p_in;
   lav_side_type       p_side_ff;

   always_comb begin
      p_in[0] = $signed(in_a[1]) * $signed(in_b[2]);
      p_in[1] = $signed(in_a[2]) * $signed(in_b[1]);
      p_in[2] = $signed(in_a[2]) * $signed(in_b[0]);
      p_in[3] = $signed(in_a[0]) * $signed(in_b[2]);
      p_in[4] = $signed(in_a[0]) * $signed(in_b[1]);
      p_in[5] = $signed(in_a[1]) * $signed(in_b[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) p_valid_ff <= 1'b0;
      else       p_valid_ff <= in_valid;
      p_ff      <= p_in;
      p_side_ff <= in_side;
   end

   // stage 2: differences, sign-extended
   logic          c_valid_ff;
   wide3_type     c_ff, c_in;
   lav_side_type  c_side_ff;
   logic signed [PW:0] diff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = (PW+1)'($signed(p_ff[2*i])) - (PW+1)'($signed(p_ff[2*i+1]));
         c_in[i] = VW'(diff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else       c_valid_ff <= p_valid_ff;
      c_ff      <= c_in;
      c_side_ff <= p_side_ff;
   end

   assign out_valid = c_valid_ff;
   assign out_vec   = c_ff;
   assign out_side  = c_side_ff;

endmodule

[design/lav_emit.sv]
// Translation column, identity fallback and three-row result serializer.
// Depends on lav_pkg.
module lav_emit import lav_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  basis3_type              in_yb,
   input  lav_side_type            in_side,
   output logic                    rsp_strobe,
   output row_type                 rsp_row_index,
   output logic signed [COL_W-1:0] rsp_col0,
   output logic signed [COL_W-1:0] rsp_col1,
   output logic signed [COL_W-1:0] rsp_col2,
   output logic signed [31:0]      rsp_shift,
   output logic                    rsp_last_row,
   output logic                    rsp_degenerate
);

   localparam int DW  = PW + 2;
   localparam int RSW = DW + 1 - FRAC_BITS;
   localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS+1)'(1) << FRAC_BITS;
   localparam logic [DW:0]  HALF    = (DW+1)'(1) << (FRAC_BITS - 1);
   localparam logic [RSW-1:0] NEG_MAX = RSW'(33'h080000000);
   localparam logic [RSW-1:0] POS_MAX = RSW'(33'h07FFFFFFF);

   typedef logic [2:0][COL_W-1:0] cols_type;

   basis3_type rows [3];
   assign rows[0] = in_side.xb;
   assign rows[1] = in_yb;
   assign rows[2] = in_side.zb;

   // stage 1: nine products and output columns
   logic               p_valid_ff, p_ok_ff;
   logic [2:0][PW-1:0] p_ff [3];
   logic [2:0][PW-1:0] p_in [3];
   cols_type           p_col_ff [3];
   cols_type           p_col_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            p_in[i][j] = $signed(rows[i][j]) * $signed(in_side.target[j]);
            if (in_side.ok)  p_col_in[i][j] = COL_W'($signed(rows[i][j]));
            else if (i == j) p_col_in[i][j] = COL_W'(ONE_Q);
            else             p_col_in[i][j] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) p_valid_ff <= 1'b0;
      else       p_valid_ff <= in_valid;
      p_ok_ff  <= in_side.ok;
      p_ff     <= p_in;
      p_col_ff <= p_col_in;
   end

   // stage 2: dot products
   logic               s_valid_ff, s_ok_ff;
   logic [DW-1:0]      s_dot_ff [3];
   logic [DW-1:0]      s_dot_in [3];
   cols_type           s_col_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s_dot_in[i] = DW'($signed(p_ff[i][0])) + DW'($signed(p_ff[i][1]))
                     + DW'($signed(p_ff[i][2]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s_valid_ff <= 1'b0;
      else       s_valid_ff <= p_valid_ff;
      s_ok_ff  <= p_ok_ff;
      s_dot_ff <= s_dot_in;
      s_col_ff <= p_col_ff;
   end

   // stage 3: magnitude and sign of the negated dot product
   logic           m_valid_ff, m_ok_ff;
   logic [DW-1:0]  m_mag_ff [3];
   logic [DW-1:0]  m_mag_in [3];
   logic [2:0]     m_neg_ff, m_neg_in;
   cols_type       m_col_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_neg_in[i] = ~s_dot_ff[i][DW-1] && (s_dot_ff[i] != '0);
         m_mag_in[i] = s_dot_ff[i][DW-1] ? (DW'(0) - s_dot_ff[i]) : s_dot_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) m_valid_ff <= 1'b0;
      else       m_valid_ff <= s_valid_ff;
      m_ok_ff  <= s_ok_ff;
      m_mag_ff <= m_mag_in;
      m_neg_ff <= m_neg_in;
      m_col_ff <= s_col_ff;
   end

   // round half away from zero, then saturate
   logic [DW:0]    rnd_sum [3];
   logic [RSW-1:0] rnd_r   [3];
   logic [RSW-1:0] rnd_c   [3];
   logic [31:0]    shift_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd_sum[i] = (DW+1)'(m_mag_ff[i]) + HALF;
         rnd_r[i]   = rnd_sum[i][DW:FRAC_BITS];
         if (m_neg_ff[i]) begin
            rnd_c[i]    = (rnd_r[i] > NEG_MAX) ? NEG_MAX : rnd_r[i];
            shift_in[i] = 32'(RSW'(0) - rnd_c[i]);
         end else begin
            rnd_c[i]    = (rnd_r[i] > POS_MAX) ? POS_MAX : rnd_r[i];
            shift_in[i] = rnd_c[i][31:0];
         end
         if (!m_ok_ff) shift_in[i] = '0;
      end
   end

   // row hold registers and serializer
   cols_type     hold_col_ff   [3];
   logic [31:0]  hold_shift_ff [3];
   logic         hold_deg_ff;
   logic         act_ff;
   row_type      row_ff;

   always_ff @(posedge clock) begin
      if (m_valid_ff) begin
         hold_col_ff   <= m_col_ff;
         hold_shift_ff <= shift_in;
         hold_deg_ff   <= ~m_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         row_ff <= ROW_X;
      end else if (m_valid_ff) begin
         act_ff <= 1'b1;
         row_ff <= ROW_X;
      end else if (act_ff) begin
         if (row_ff == ROW_Z) act_ff <= 1'b0;
         else                 row_ff <= row_ff + 2'd1;
      end
   end

   assign rsp_strobe     = act_ff;
   assign rsp_row_index  = row_ff;
   assign rsp_col0       = $signed(hold_col_ff[row_ff][0]);
   assign rsp_col1       = $signed(hold_col_ff[row_ff][1]);
   assign rsp_col2       = $signed(hold_col_ff[row_ff][2]);
   assign rsp_shift      = $signed(hold_shift_ff[row_ff]);
   assign rsp_last_row   = (row_ff == ROW_Z);
   assign rsp_degenerate = hold_deg_ff;

endmodule
